// File: rtl/bla_pkg.sv
// Shared types and constants of the binary lifting ancestor engine.
// No dependencies; used by bla_tables and binary_lifting_ancestor_engine_core.
package bla_pkg;

   localparam int NODE_W = 10;   // node index, depth and step fields
   localparam int CSR_W  = 11;   // node_count register
   localparam int OP_W   = 2;

   localparam logic [CSR_W-1:0] CSR_RESET = 11'd1024;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_KTH   = 2'd2,
      OP_LCA   = 2'd3
   } op_type;

   localparam logic STATUS_ANSWER = 1'b0;
   localparam logic STATUS_ACK    = 1'b1;

endpackage

// File: rtl/bla_tables.sv
// Jump table and depth store: single write port, single registered read port each.
// Depends on bla_pkg for the node width.
module bla_tables #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 11
) (
   input  logic                          clock,
   input  logic                          jt_wr_en,
   input  logic [$clog2(LEVELS)+$clog2(MAX_NODES)-1:0] jt_wr_addr,
   input  logic [bla_pkg::NODE_W-1:0]    jt_wr_data,
   input  logic [$clog2(LEVELS)+$clog2(MAX_NODES)-1:0] jt_rd_addr,
   output logic [bla_pkg::NODE_W-1:0]    jt_rd_data,
   input  logic                          ds_wr_en,
   input  logic [$clog2(MAX_NODES)-1:0]  ds_wr_addr,
   input  logic [bla_pkg::NODE_W-1:0]    ds_wr_data,
   input  logic [$clog2(MAX_NODES)-1:0]  ds_rd_addr,
   output logic [bla_pkg::NODE_W-1:0]    ds_rd_data
);

   localparam int AW       = $clog2(MAX_NODES);
   localparam int JT_DEPTH = LEVELS * (1 << AW);

   // jump table is addressed {level, node}
   logic [bla_pkg::NODE_W-1:0] jt_mem [JT_DEPTH];
   logic [bla_pkg::NODE_W-1:0] ds_mem [MAX_NODES];

   always_ff @(posedge clock) begin
      if (jt_wr_en) begin
         jt_mem[jt_wr_addr] <= jt_wr_data;
      end
      jt_rd_data <= jt_mem[jt_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ds_wr_en) begin
         ds_mem[ds_wr_addr] <= ds_wr_data;
      end
      ds_rd_data <= ds_mem[ds_rd_addr];
   end

endmodule

// File: rtl/binary_lifting_ancestor_engine_core.sv
// Binary lifting ancestor engine: command sequencer around the jump table and depth store.
// Depends on bla_pkg and bla_tables.
// Operations: load writes level 0 of the jump table and the depth store; build fills levels
//   1 to LEVELS-1 for the n nodes in use (answering without table access when n is zero); k-th
//   ancestor climbs by the set bits of step_count below LEVELS; common ancestor lifts the deeper
//   node by the depth gap, then descends the levels unless lifting meets.
// One item at a time: a new request is accepted only while the sequencer is idle.
// Synchronous active-high reset clears the sequencer and sets node_count to 1024; table
//   contents are undefined until loaded. Results cannot be stalled by the receiver.
module binary_lifting_ancestor_engine_core #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bla_pkg::OP_W-1:0]      req_op,
   input  logic [bla_pkg::NODE_W-1:0]    req_node_a,
   input  logic [bla_pkg::NODE_W-1:0]    req_node_b,
   input  logic [bla_pkg::NODE_W-1:0]    req_parent_node,
   input  logic [bla_pkg::NODE_W-1:0]    req_node_depth,
   input  logic [bla_pkg::NODE_W-1:0]    req_step_count,
   output logic                          rsp_valid,
   output logic [bla_pkg::NODE_W-1:0]    rsp_result_node,
   output logic                          rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bla_pkg::CSR_W-1:0]     csr_data
);

   localparam int NW    = bla_pkg::NODE_W;
   localparam int AW    = $clog2(MAX_NODES);
   localparam int LW    = $clog2(LEVELS);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int SAT_W = (CNT_W > bla_pkg::CSR_W) ? CNT_W : bla_pkg::CSR_W;
   localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_B_RD1,
      ST_B_RD2,
      ST_B_WR,
      ST_C_STEP,
      ST_C_WAIT,
      ST_M_RDA,
      ST_M_RDB,
      ST_M_CMP,
      ST_D_RDA,
      ST_D_RDB,
      ST_D_CMP,
      ST_F_WAIT
   } state_type;

   // node index to store slot, i.e. modulo MAX_NODES
   function automatic logic [AW-1:0] slot(input logic [NW-1:0] v);
      logic [NW-1:0] r;
      r = v;
      if (MAX_NODES < (1 << NW)) begin
         if ((MAX_NODES & (MAX_NODES - 1)) == 0) begin
            r = v & NW'(MAX_NODES - 1);
         end else begin
            for (int s = NW - 1; s >= 0; s--) begin
               if ((MAX_NODES << s) < (1 << NW)) begin
                  if (r >= NW'(MAX_NODES << s)) begin
                     r = r - NW'(MAX_NODES << s);
                  end
               end
            end
         end
      end
      return AW'(r);
   endfunction

   state_type            state_ff;
   bla_pkg::op_type      op_ff;
   logic [NW-1:0]        node_ff;
   logic [NW-1:0]        b_ff;
   logic [NW-1:0]        par_ff;
   logic [NW-1:0]        dep_ff;
   logic [NW-1:0]        steps_ff;
   logic [NW-1:0]        da_ff;
   logic [NW-1:0]        ca_ff;
   logic [LW-1:0]        lvl_ff;
   logic [CNT_W-1:0]     j_ff;
   logic [CNT_W-1:0]     n_ff;
   logic                 rsp_valid_ff;
   logic [NW-1:0]        rsp_node_ff;
   logic                 rsp_status_ff;
   logic [bla_pkg::CSR_W-1:0] csr_ff;

   logic [NW-1:0]        jt_rd_data;
   logic [NW-1:0]        ds_rd_data;

   logic [LW-1:0]        rd_lvl_c;
   logic                 rd_use_idx_c;
   logic [NW-1:0]        rd_node_c;
   logic [AW-1:0]        slot_c;
   logic [AW-1:0]        rd_idx_c;
   logic                 jt_wr_en_c;
   logic [LW-1:0]        jt_wr_lvl_c;
   logic [AW-1:0]        jt_wr_idx_c;
   logic [NW-1:0]        jt_wr_data_c;
   logic                 ds_wr_en_c;
   logic [NW-1:0]        next_a_c;
   logic [NW-1:0]        climb_node_c;
   logic [SAT_W-1:0]     n_wide_c;
   logic [CNT_W-1:0]     n_sat_c;
   logic                 accept_c;

   assign accept_c  = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_node = rsp_node_ff;
   assign rsp_status      = rsp_status_ff;

   // node_count saturates to the store size
   always_comb begin
      n_wide_c = SAT_W'(csr_ff);
      if (n_wide_c > SAT_W'(MAX_NODES)) begin
         n_wide_c = SAT_W'(MAX_NODES);
      end
      n_sat_c = CNT_W'(n_wide_c);
   end

   // descent: keep the pair while the ancestors agree
   assign next_a_c     = (ca_ff != jt_rd_data) ? ca_ff : node_ff;
   assign climb_node_c = (state_ff == ST_C_WAIT) ? jt_rd_data : node_ff;

   // memory address and write selection; one slot reduction shared by all node-addressed accesses
   always_comb begin
      rd_lvl_c     = lvl_ff;
      rd_use_idx_c = 1'b0;
      rd_node_c    = node_ff;
      jt_wr_en_c   = 1'b0;
      jt_wr_lvl_c  = lvl_ff;
      jt_wr_idx_c  = j_ff[AW-1:0];
      jt_wr_data_c = jt_rd_data;
      ds_wr_en_c   = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            jt_wr_en_c   = 1'b1;
            jt_wr_lvl_c  = '0;
            jt_wr_idx_c  = slot_c;
            jt_wr_data_c = par_ff;
            ds_wr_en_c   = 1'b1;
         end
         ST_B_RD1: begin
            rd_lvl_c     = lvl_ff - LW'(1);
            rd_use_idx_c = 1'b1;
         end
         ST_B_RD2: begin
            rd_lvl_c  = lvl_ff - LW'(1);
            rd_node_c = jt_rd_data;
         end
         ST_B_WR: begin
            jt_wr_en_c = 1'b1;
         end
         ST_M_RDB, ST_D_RDB: begin
            rd_node_c = b_ff;
         end
         ST_D_CMP: begin
            rd_node_c = next_a_c;
            rd_lvl_c  = (lvl_ff == '0) ? '0 : lvl_ff - LW'(1);
         end
         default: begin
         end
      endcase
      slot_c   = slot(rd_node_c);
      rd_idx_c = rd_use_idx_c ? j_ff[AW-1:0] : slot_c;
   end

   bla_tables #(
      .MAX_NODES (MAX_NODES),
      .LEVELS    (LEVELS)
   ) u_tables (
      .clock      (clock),
      .jt_wr_en   (jt_wr_en_c),
      .jt_wr_addr ({jt_wr_lvl_c, jt_wr_idx_c}),
      .jt_wr_data (jt_wr_data_c),
      .jt_rd_addr ({rd_lvl_c, rd_idx_c}),
      .jt_rd_data (jt_rd_data),
      .ds_wr_en   (ds_wr_en_c),
      .ds_wr_addr (slot_c),
      .ds_wr_data (dep_ff),
      .ds_rd_addr (slot_c),
      .ds_rd_data (ds_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= bla_pkg::CSR_RESET;
      end else if (csr_valid && csr_ready) begin
         csr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept_c) begin
                  op_ff    <= bla_pkg::op_type'(req_op);
                  node_ff  <= req_node_a;
                  b_ff     <= req_node_b;
                  par_ff   <= req_parent_node;
                  dep_ff   <= req_node_depth;
                  steps_ff <= req_step_count;
                  lvl_ff   <= '0;
                  j_ff     <= '0;
                  n_ff     <= n_sat_c;
                  unique case (bla_pkg::op_type'(req_op))
                     bla_pkg::OP_LOAD:  state_ff <= ST_LOAD;
                     bla_pkg::OP_BUILD: begin
                        if (n_sat_c == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_node_ff   <= '0;
                           rsp_status_ff <= bla_pkg::STATUS_ACK;
                        end else begin
                           lvl_ff   <= LW'(1);
                           state_ff <= ST_B_RD1;
                        end
                     end
                     bla_pkg::OP_KTH:   state_ff <= ST_C_STEP;
                     bla_pkg::OP_LCA:   state_ff <= ST_M_RDA;
                     default:           state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_LOAD: begin
               rsp_valid_ff  <= 1'b1;
               rsp_node_ff   <= '0;
               rsp_status_ff <= bla_pkg::STATUS_ACK;
               state_ff      <= ST_IDLE;
            end
            ST_B_RD1: state_ff <= ST_B_RD2;
            ST_B_RD2: state_ff <= ST_B_WR;
            ST_B_WR: begin
               state_ff <= ST_B_RD1;
               if (j_ff == n_ff - CNT_W'(1)) begin
                  j_ff <= '0;
                  if (lvl_ff == LVL_LAST) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_node_ff   <= '0;
                     rsp_status_ff <= bla_pkg::STATUS_ACK;
                     state_ff      <= ST_IDLE;
                  end else begin
                     lvl_ff <= lvl_ff + LW'(1);
                  end
               end else begin
                  j_ff <= j_ff + CNT_W'(1);
               end
            end
            ST_C_STEP, ST_C_WAIT: begin
               if (state_ff == ST_C_STEP && steps_ff[0]) begin
                  state_ff <= ST_C_WAIT;
               end else begin
                  node_ff  <= climb_node_c;
                  steps_ff <= steps_ff >> 1;
                  if (lvl_ff != LVL_LAST) begin
                     lvl_ff   <= lvl_ff + LW'(1);
                     state_ff <= ST_C_STEP;
                  end else if (op_ff == bla_pkg::OP_KTH || climb_node_c == b_ff) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_node_ff   <= climb_node_c;
                     rsp_status_ff <= bla_pkg::STATUS_ANSWER;
                     state_ff      <= ST_IDLE;
                  end else begin
                     lvl_ff   <= LVL_LAST;
                     state_ff <= ST_D_RDA;
                  end
               end
            end
            ST_M_RDA: state_ff <= ST_M_RDB;
            ST_M_RDB: begin
               da_ff    <= ds_rd_data;
               state_ff <= ST_M_CMP;
            end
            ST_M_CMP: begin
               // deeper node goes into node_ff and is lifted by the depth gap
               if (da_ff < ds_rd_data) begin
                  node_ff  <= b_ff;
                  b_ff     <= node_ff;
                  steps_ff <= ds_rd_data - da_ff;
               end else begin
                  steps_ff <= da_ff - ds_rd_data;
               end
               lvl_ff   <= '0;
               state_ff <= ST_C_STEP;
            end
            ST_D_RDA: state_ff <= ST_D_RDB;
            ST_D_RDB: begin
               ca_ff    <= jt_rd_data;
               state_ff <= ST_D_CMP;
            end
            ST_D_CMP: begin
               node_ff <= next_a_c;
               if (ca_ff != jt_rd_data) begin
                  b_ff <= jt_rd_data;
               end
               if (lvl_ff == '0) begin
                  state_ff <= ST_F_WAIT;
               end else begin
                  lvl_ff   <= lvl_ff - LW'(1);
                  state_ff <= ST_D_RDB;
               end
            end
            ST_F_WAIT: begin
               rsp_valid_ff  <= 1'b1;
               rsp_node_ff   <= jt_rd_data;
               rsp_status_ff <= bla_pkg::STATUS_ANSWER;
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept_c |=> (busy || rsp_valid))
      else $error("accepted request neither started nor answered");

   a_rsp_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer still busy");

   a_ack_carries_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bla_pkg::STATUS_ACK) |-> (rsp_result_node == '0))
      else $error("acknowledge with non-zero node");

   a_build_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_B_RD1 || state_ff == ST_B_RD2 || state_ff == ST_B_WR)
      |-> (j_ff < n_ff && lvl_ff != '0))
      else $error("build index or level out of range");

   a_final_read_follows_descent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_F_WAIT) |-> ($past(state_ff) == ST_D_CMP && $past(lvl_ff) == '0))
      else $error("final parent read without completed descent");

endmodule
